FILE: design/cdac_pkg.sv
`timescale 1ns / 1ps
// Package for the civil date add/compare unit: widths, divide-by-constant
// reciprocals, calendar tables and the sideband type. No dependencies.
package cdac_pkg;

   localparam int YEAR_BITS   = 16;
   localparam int OFFSET_BITS = 25;

   localparam int CYCLE_DAYS = 146097;
   localparam int YEAR_MAX   = (2 ** (YEAR_BITS - 1)) - 1;
   localparam int YEAR_MIN   = -(2 ** (YEAR_BITS - 1));

   // Bias (in 400-year cycles) that keeps the shifted year non-negative
   localparam int YCYC_BIAS = (2 ** (YEAR_BITS - 1)) / 400 + 1;
   localparam int YU_BITS   = YEAR_BITS + 1;
   localparam int YQ_BITS   = $clog2(2 * YCYC_BIAS + 1);
   localparam int CYC_BITS  = YQ_BITS + 1;
   localparam int DOC_BITS  = 19;
   localparam int CYCD_BITS = $clog2(YCYC_BIAS * CYCLE_DAYS) + 2;
   localparam int DN_BITS   = CYCD_BITS + 1;
   localparam int NP_BITS   = ((DN_BITS > OFFSET_BITS) ? DN_BITS : OFFSET_BITS) + 2;

   // Bias (in 400-year cycles) that keeps the shifted day number non-negative
   localparam int FCYC_BIAS = (2 ** (OFFSET_BITS - 1)) / CYCLE_DAYS + YCYC_BIAS + 2;
   localparam int U2_BITS   = NP_BITS + 1;
   localparam int Q2_BITS   = $clog2(2 * FCYC_BIAS + 2);
   localparam int CYC2_BITS = Q2_BITS + 1;
   localparam int RY_BITS   = $clog2(400 * FCYC_BIAS) + 2;

   // Bias (in multiples of 25) for the leap-year residue
   localparam int Y25_BIAS = 25 * ((2 ** (YEAR_BITS - 1)) / 25 + 1);
   localparam int VQ_BITS  = YEAR_BITS - 3;

   // Reciprocals, floor(2**SH / divisor); the quotient may come out one low
   localparam int M400     = 167772;
   localparam int SH400    = 26;
   localparam int M25      = 167772;
   localparam int SH25     = 22;
   localparam int M146097  = 7525901;
   localparam int SH146097 = 40;
   localparam int M1460    = 735439;
   localparam int SH1460   = 30;
   localparam int M365     = 2941758;
   localparam int SH365    = 30;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_CMP = 1'b1;

   localparam logic [1:0] ORD_LESS    = 2'b11;
   localparam logic [1:0] ORD_EQUAL   = 2'b00;
   localparam logic [1:0] ORD_GREATER = 2'b01;

   typedef struct packed {
      logic       op;
      logic       date_valid;
      logic [1:0] order;
   } side_type;

   // First day-of-year of month index k, counted from March (k = 0)
   function automatic logic [8:0] mp_start(input logic [3:0] k);
      logic [8:0] s;
      case (k)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         4'd12:   s = 9'd367;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   function automatic logic [1:0] div100(input logic [8:0] yoc);
      return 2'(yoc >= 9'd100) + 2'(yoc >= 9'd200) + 2'(yoc >= 9'd300);
   endfunction

   function automatic logic [2:0] div36524(input logic [17:0] doc);
      return 3'(doc >= 18'd36524) + 3'(doc >= 18'd73048) + 3'(doc >= 18'd109572)
           + 3'(doc >= 18'd146096);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] n;
      case (m)
         4'd2:                      n = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
         default:                   n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

FILE: design/civil_date_add_and_compare.sv
`timescale 1ns / 1ps
// Civil date add/compare unit, top level. A taken request runs through the
// input, a-c, e, f1-f8 and output registers. Throughput: one request per
// cycle, set by the fully pipelined divide-by-constant stages; busy stays
// low. Reset (synchronous, active high) clears all valid bits; the data
// registers are not reset. The receiver cannot stall, so no request is
// ever held. Depends on cdac_pkg, cdac_to_days and cdac_from_days.
module civil_date_add_and_compare (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic                                        req_op,
   input  logic signed [cdac_pkg::YEAR_BITS-1:0]       req_year,
   input  logic [3:0]                                  req_month,
   input  logic [4:0]                                  req_day,
   input  logic signed [cdac_pkg::OFFSET_BITS-1:0]     req_day_offset,
   input  logic signed [cdac_pkg::YEAR_BITS-1:0]       req_other_year,
   input  logic [3:0]                                  req_other_month,
   input  logic [4:0]                                  req_other_day,
   output logic                                        rsp_valid,
   output logic signed [cdac_pkg::YEAR_BITS-1:0]       rsp_result_year,
   output logic [3:0]                                  rsp_result_month,
   output logic [4:0]                                  rsp_result_day,
   output logic signed [1:0]                           rsp_order,
   output logic                                        rsp_date_valid,
   output logic                                        rsp_out_of_range
);
   localparam int YB  = cdac_pkg::YEAR_BITS;
   localparam int OB  = cdac_pkg::OFFSET_BITS;
   localparam int DNB = cdac_pkg::DN_BITS;
   localparam int NPB = cdac_pkg::NP_BITS;
   localparam int UB  = cdac_pkg::U2_BITS;
   localparam int RB  = cdac_pkg::RY_BITS;
   localparam int VQ  = cdac_pkg::VQ_BITS;

   // Every cycle can take a request: the pipeline never backs up.
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // ---------------------------------------------------------------------
   // Input register: capture the request as-is.
   // ---------------------------------------------------------------------
   logic                 vld0_ff, op0_ff;
   logic signed [YB-1:0] y0_ff, oy0_ff;
   logic [3:0]           m0_ff, om0_ff;
   logic [4:0]           d0_ff, od0_ff;
   logic signed [OB-1:0] off0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else begin
         vld0_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      op0_ff  <= req_op;
      y0_ff   <= req_year;
      m0_ff   <= req_month;
      d0_ff   <= req_day;
      off0_ff <= req_day_offset;
      oy0_ff  <= req_other_year;
      om0_ff  <= req_other_month;
      od0_ff  <= req_other_day;
   end

   // ---------------------------------------------------------------------
   // Both dates to day counts, three stages each (a, b, c).
   // ---------------------------------------------------------------------
   logic signed [DNB-1:0] dn_first, dn_other;

   cdac_to_days u_first (
      .clock   (clock),
      .year    (y0_ff),
      .month   (m0_ff),
      .day     (d0_ff),
      .day_num (dn_first)
   );

   cdac_to_days u_other (
      .clock   (clock),
      .year    (oy0_ff),
      .month   (om0_ff),
      .day     (od0_ff),
      .day_num (dn_other)
   );

   // ---------------------------------------------------------------------
   // Date check of the first date, alongside stages a and b.
   // Leap: y % 4 == 0 and (y % 25 != 0 or y % 16 == 0). The year is biased
   // by a multiple of 25 so the residue comes from an unsigned reciprocal.
   // ---------------------------------------------------------------------
   logic [YB:0]     v_a;
   logic [YB+18:0]  pv_a;
   logic [YB:0]     v_a_ff;
   logic [VQ-1:0]   qv_a_ff;
   logic [3:0]      ylow_a_ff, m_a_ff;
   logic [4:0]      d_a_ff;

   assign v_a  = (YB+1)'((YB+2)'(y0_ff) + (YB+2)'(cdac_pkg::Y25_BIAS));
   assign pv_a = (YB+19)'(v_a) * (YB+19)'(cdac_pkg::M25);

   always_ff @(posedge clock) begin
      v_a_ff    <= v_a;
      qv_a_ff   <= pv_a[cdac_pkg::SH25 +: VQ];
      ylow_a_ff <= y0_ff[3:0];
      m_a_ff    <= m0_ff;
      d_a_ff    <= d0_ff;
   end

   logic [YB:0] rv_b;
   logic        y25_b, leap_b, dval_b;

   assign rv_b   = v_a_ff - (YB+1)'(qv_a_ff) * (YB+1)'(25);
   // residue is rv_b or rv_b - 25; zero exactly when rv_b is 0 or 25
   assign y25_b  = (rv_b == '0) || (rv_b == (YB+1)'(25));
   assign leap_b = (ylow_a_ff[1:0] == 2'b00) && (!y25_b || ylow_a_ff == 4'd0);
   assign dval_b = (m_a_ff >= 4'd1) && (m_a_ff <= 4'd12) && (d_a_ff != 5'd0)
                && (d_a_ff <= cdac_pkg::month_len(m_a_ff, leap_b));

   // ---------------------------------------------------------------------
   // Hold op, offset, valid and date check through stages a, b, c.
   // ---------------------------------------------------------------------
   logic [2:0]           vld_abc_ff;
   logic                 op_a_ff, op_b_ff, op_c_ff;
   logic signed [OB-1:0] off_a_ff, off_b_ff, off_c_ff;
   logic                 dval_b_ff, dval_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_abc_ff <= '0;
      end else begin
         vld_abc_ff <= {vld_abc_ff[1:0], vld0_ff};
      end
   end

   always_ff @(posedge clock) begin
      op_a_ff   <= op0_ff;
      op_b_ff   <= op_a_ff;
      op_c_ff   <= op_b_ff;
      off_a_ff  <= off0_ff;
      off_b_ff  <= off_a_ff;
      off_c_ff  <= off_b_ff;
      dval_b_ff <= dval_b;
      dval_c_ff <= dval_b_ff;
   end

   // ---------------------------------------------------------------------
   // Stage e: shifted day count (the epoch shift cancels, so add the offset
   // straight to the cycle-relative count), bias it non-negative, and order
   // the two dates.
   // ---------------------------------------------------------------------
   logic signed [NPB-1:0] np_e;
   logic [UB-1:0]         u2_in, u2_ff;
   logic [1:0]            ord_e;
   logic                  vld_e_ff;
   cdac_pkg::side_type    side_in, side_e_ff;

   assign np_e  = NPB'(dn_first) + NPB'(off_c_ff);
   assign u2_in = UB'(np_e) + UB'(cdac_pkg::FCYC_BIAS * cdac_pkg::CYCLE_DAYS);

   always_comb begin
      if (dn_first < dn_other) begin
         ord_e = cdac_pkg::ORD_LESS;
      end else if (dn_first > dn_other) begin
         ord_e = cdac_pkg::ORD_GREATER;
      end else begin
         ord_e = cdac_pkg::ORD_EQUAL;
      end
   end

   always_comb begin
      side_in.op         = op_c_ff;
      side_in.date_valid = dval_c_ff;
      side_in.order      = ord_e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_e_ff <= 1'b0;
      end else begin
         vld_e_ff <= vld_abc_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      u2_ff     <= u2_in;
      side_e_ff <= side_in;
   end

   // ---------------------------------------------------------------------
   // Day count back to a civil date, eight stages.
   // ---------------------------------------------------------------------
   logic                 vld_f;
   cdac_pkg::side_type   side_f;
   logic signed [RB-1:0] year_f;
   logic [3:0]           month_f;
   logic [4:0]           day_f;

   cdac_from_days u_from (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_e_ff),
      .in_side   (side_e_ff),
      .in_days   (u2_ff),
      .out_valid (vld_f),
      .out_side  (side_f),
      .out_year  (year_f),
      .out_month (month_f),
      .out_day   (day_f)
   );

   // ---------------------------------------------------------------------
   // Output register: range check on the year, zero the fields that the op
   // does not produce, strobe the result for one cycle.
   // ---------------------------------------------------------------------
   logic                 oor_f;
   logic                 rsp_valid_in, rsp_valid_ff;
   logic signed [YB-1:0] ry_in, ry_ff;
   logic [3:0]           rm_in, rm_ff;
   logic [4:0]           rd_in, rd_ff;
   logic [1:0]           ord_in, ord_ff;
   logic                 dv_in, dv_ff;
   logic                 oor_in, oor_ff;

   assign oor_f = (year_f > RB'(cdac_pkg::YEAR_MAX)) || (year_f < RB'(cdac_pkg::YEAR_MIN));

   always_comb begin
      rsp_valid_in = vld_f;
      dv_in        = side_f.date_valid;
      ry_in        = '0;
      rm_in        = 4'd0;
      rd_in        = 5'd0;
      ord_in       = cdac_pkg::ORD_EQUAL;
      oor_in       = 1'b0;
      if (side_f.op == cdac_pkg::OP_CMP) begin
         ord_in = side_f.order;
      end else if (oor_f) begin
         oor_in = 1'b1;
      end else begin
         ry_in = year_f[YB-1:0];
         rm_in = month_f;
         rd_in = day_f;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ry_ff  <= ry_in;
      rm_ff  <= rm_in;
      rd_ff  <= rd_in;
      ord_ff <= ord_in;
      dv_ff  <= dv_in;
      oor_ff <= oor_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_year  = ry_ff;
   assign rsp_result_month = rm_ff;
   assign rsp_result_day   = rd_ff;
   assign rsp_order        = ord_ff;
   assign rsp_date_valid   = dv_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

FILE: design/cdac_to_days.sv
`timescale 1ns / 1ps
// Civil date to day count (relative to the era epoch), three register stages.
// Depends on cdac_pkg.
module cdac_to_days (
   input  logic                                  clock,
   input  logic signed [cdac_pkg::YEAR_BITS-1:0] year,
   input  logic [3:0]                            month,
   input  logic [4:0]                            day,
   output logic signed [cdac_pkg::DN_BITS-1:0]   day_num
);
   localparam int YB  = cdac_pkg::YEAR_BITS;
   localparam int YU  = cdac_pkg::YU_BITS;
   localparam int YQ  = cdac_pkg::YQ_BITS;
   localparam int CB  = cdac_pkg::CYC_BITS;
   localparam int DB  = cdac_pkg::DOC_BITS;
   localparam int CDB = cdac_pkg::CYCD_BITS;
   localparam int DNB = cdac_pkg::DN_BITS;

   // stage a: biased year, approximate year / 400
   logic                 m_le2;
   logic signed [YB+1:0] ys;
   logic [YU-1:0]        u_in, u_ff;
   logic [YU+17:0]       prod_a;
   logic [YQ-1:0]        qa_in, qa_ff;
   logic [3:0]           mon_ff;
   logic [4:0]           day_ff;

   assign m_le2  = (month <= 4'd2);
   assign ys     = (YB+2)'(year) - (YB+2)'(m_le2) + (YB+2)'(cdac_pkg::YCYC_BIAS * 400);
   assign u_in   = ys[YU-1:0];
   assign prod_a = (YU+18)'(u_in) * (YU+18)'(cdac_pkg::M400);
   assign qa_in  = prod_a[cdac_pkg::SH400 +: YQ];

   always_ff @(posedge clock) begin
      u_ff   <= u_in;
      qa_ff  <= qa_in;
      mon_ff <= month;
      day_ff <= day;
   end

   // stage b: fix the quotient, year of cycle, day of year
   logic [YU-1:0]        r_b;
   logic                 ge_b;
   logic [YQ-1:0]        q_b;
   logic [3:0]           mm_b;
   logic [8:0]           yoc_in, yoc_ff;
   logic signed [CB-1:0] cyc_in, cyc_ff;
   logic signed [9:0]    doy_in, doy_ff;

   assign r_b    = u_ff - YU'(qa_ff) * YU'(400);
   assign ge_b   = (r_b >= YU'(400));
   assign yoc_in = ge_b ? 9'(r_b - YU'(400)) : 9'(r_b);
   assign q_b    = qa_ff + YQ'(ge_b);
   assign cyc_in = CB'(q_b) - CB'(cdac_pkg::YCYC_BIAS);
   assign mm_b   = (mon_ff > 4'd2) ? mon_ff - 4'd3 : mon_ff + 4'd9;
   assign doy_in = 10'(cdac_pkg::mp_start(mm_b)) + 10'(day_ff) - 10'sd1;

   always_ff @(posedge clock) begin
      yoc_ff <= yoc_in;
      cyc_ff <= cyc_in;
      doy_ff <= doy_in;
   end

   // stage c: day of cycle and cycle offset
   logic [DB-1:0]         ypart;
   logic signed [DB-1:0]  doc_in, doc_ff;
   logic signed [CDB-1:0] cycd_in, cycd_ff;

   assign ypart   = DB'(yoc_ff) * DB'(365) + DB'(yoc_ff >> 2) - DB'(cdac_pkg::div100(yoc_ff));
   assign doc_in  = ypart + DB'(doy_ff);
   assign cycd_in = CDB'(cyc_ff) * CDB'(cdac_pkg::CYCLE_DAYS);

   always_ff @(posedge clock) begin
      doc_ff  <= doc_in;
      cycd_ff <= cycd_in;
   end

   assign day_num = DNB'(cycd_ff) + DNB'(doc_ff);

endmodule

FILE: design/cdac_from_days.sv
`timescale 1ns / 1ps
// Biased day count back to civil date, eight register stages; valid and
// sideband travel alongside. Depends on cdac_pkg.
module cdac_from_days (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  cdac_pkg::side_type                     in_side,
   input  logic [cdac_pkg::U2_BITS-1:0]           in_days,
   output logic                                   out_valid,
   output cdac_pkg::side_type                     out_side,
   output logic signed [cdac_pkg::RY_BITS-1:0]    out_year,
   output logic [3:0]                             out_month,
   output logic [4:0]                             out_day
);
   localparam int UB  = cdac_pkg::U2_BITS;
   localparam int QB  = cdac_pkg::Q2_BITS;
   localparam int CB  = cdac_pkg::CYC2_BITS;
   localparam int RB  = cdac_pkg::RY_BITS;
   localparam int NST = 8;

   logic [NST-1:0]     vld_ff;
   cdac_pkg::side_type side_ff [NST];

   // advance valid bits and sideband with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      for (int i = 1; i < NST; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // f1: approximate cycle count
   logic [UB+22:0] prod1;
   logic [QB-1:0]  q1_ff;
   logic [UB-1:0]  u1_ff;

   assign prod1 = (UB+23)'(in_days) * (UB+23)'(cdac_pkg::M146097);

   always_ff @(posedge clock) begin
      q1_ff <= prod1[cdac_pkg::SH146097 +: QB];
      u1_ff <= in_days;
   end

   // f2: fix cycle count, day of cycle
   logic [UB-1:0]        r2;
   logic                 ge2;
   logic [QB-1:0]        q2;
   logic [17:0]          doc2_ff;
   logic signed [CB-1:0] cyc2_ff;

   assign r2  = u1_ff - UB'(q1_ff) * UB'(cdac_pkg::CYCLE_DAYS);
   assign ge2 = (r2 >= UB'(cdac_pkg::CYCLE_DAYS));
   assign q2  = q1_ff + QB'(ge2);

   always_ff @(posedge clock) begin
      doc2_ff <= ge2 ? 18'(r2 - UB'(cdac_pkg::CYCLE_DAYS)) : 18'(r2);
      cyc2_ff <= CB'(q2) - CB'(cdac_pkg::FCYC_BIAS);
   end

   // f3: doc / 1460 estimate, doc / 36524, last day of cycle
   logic [37:0]          prod3;
   logic [6:0]           t3_ff;
   logic [2:0]           c3_ff;
   logic                 last3_ff;
   logic [17:0]          doc3_ff;
   logic signed [CB-1:0] cyc3_ff;

   assign prod3 = 38'(doc2_ff) * 38'(cdac_pkg::M1460);

   always_ff @(posedge clock) begin
      t3_ff    <= prod3[cdac_pkg::SH1460 +: 7];
      c3_ff    <= cdac_pkg::div36524(doc2_ff);
      last3_ff <= (doc2_ff == 18'(cdac_pkg::CYCLE_DAYS - 1));
      doc3_ff  <= doc2_ff;
      cyc3_ff  <= cyc2_ff;
   end

   // f4: fix doc / 1460, leap-corrected day count
   logic [17:0]          r4;
   logic [6:0]           t4;
   logic [17:0]          s4_ff, doc4_ff;
   logic signed [CB-1:0] cyc4_ff;

   assign r4 = doc3_ff - 18'(t3_ff) * 18'd1460;
   assign t4 = t3_ff + 7'(r4 >= 18'd1460);

   always_ff @(posedge clock) begin
      s4_ff   <= doc3_ff - 18'(t4) + 18'(c3_ff) - 18'(last3_ff);
      doc4_ff <= doc3_ff;
      cyc4_ff <= cyc3_ff;
   end

   // f5: year of cycle estimate
   logic [39:0]          prod5;
   logic [8:0]           ya5_ff;
   logic [17:0]          s5_ff, doc5_ff;
   logic signed [CB-1:0] cyc5_ff;

   assign prod5 = 40'(s4_ff) * 40'(cdac_pkg::M365);

   always_ff @(posedge clock) begin
      ya5_ff  <= prod5[cdac_pkg::SH365 +: 9];
      s5_ff   <= s4_ff;
      doc5_ff <= doc4_ff;
      cyc5_ff <= cyc4_ff;
   end

   // f6: days in the whole years of the estimate
   logic [17:0]          p6_ff, s6_ff, doc6_ff;
   logic [8:0]           ya6_ff;
   logic signed [CB-1:0] cyc6_ff;

   always_ff @(posedge clock) begin
      p6_ff   <= 18'(ya5_ff) * 18'd365;
      ya6_ff  <= ya5_ff;
      s6_ff   <= s5_ff;
      doc6_ff <= doc5_ff;
      cyc6_ff <= cyc5_ff;
   end

   // f7: fix year of cycle, day of year (from March)
   logic                 ge7;
   logic [8:0]           yoc7;
   logic [17:0]          p7, doy7;
   logic [8:0]           yoc7_ff, doy7_ff;
   logic signed [RB-1:0] ycyc7_ff;

   assign ge7  = ((s6_ff - p6_ff) >= 18'd365);
   assign yoc7 = ya6_ff + 9'(ge7);
   assign p7   = ge7 ? p6_ff + 18'd365 : p6_ff;
   assign doy7 = doc6_ff - p7 - 18'(yoc7 >> 2) + 18'(cdac_pkg::div100(yoc7));

   always_ff @(posedge clock) begin
      yoc7_ff  <= yoc7;
      doy7_ff  <= doy7[8:0];
      ycyc7_ff <= RB'(cyc6_ff) * RB'(400);
   end

   // f8: month, day, year
   logic [3:0] mp8;
   logic       carry8;

   always_comb begin
      mp8 = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (doy7_ff >= cdac_pkg::mp_start(4'(k))) begin
            mp8 = 4'(k);
         end
      end
   end

   assign carry8 = (mp8 >= 4'd10);

   always_ff @(posedge clock) begin
      out_year  <= ycyc7_ff + RB'(yoc7_ff) + RB'(carry8);
      out_month <= carry8 ? mp8 - 4'd9 : mp8 + 4'd3;
      out_day   <= 5'(doy7_ff - cdac_pkg::mp_start(mp8) + 9'd1);
   end

   assign out_valid = vld_ff[NST-1];
   assign out_side  = side_ff[NST-1];

endmodule

FILE: tb/sv/civil_date_add_and_compare_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the civil date add/compare unit: random and corner
// requests, a built-in day-number predictor, per-field result checks.
// Depends on cdac_pkg and the civil_date_add_and_compare RTL.
module civil_date_add_and_compare_test;

   typedef struct {
      logic                                    op;
      logic signed [cdac_pkg::YEAR_BITS-1:0]   year;
      logic [3:0]                              month;
      logic [4:0]                              day;
      logic signed [cdac_pkg::OFFSET_BITS-1:0] day_offset;
      logic signed [cdac_pkg::YEAR_BITS-1:0]   other_year;
      logic [3:0]                              other_month;
      logic [4:0]                              other_day;
   } date_request_type;

   typedef struct {
      logic signed [cdac_pkg::YEAR_BITS-1:0] year;
      logic [3:0]                            month;
      logic [4:0]                            day;
      logic [1:0]                            order;
      logic                                  date_valid;
      logic                                  out_of_range;
   } date_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic                                    req_op = cdac_pkg::OP_ADD;
   logic signed [cdac_pkg::YEAR_BITS-1:0]   req_year = '0;
   logic [3:0]                              req_month = '0;
   logic [4:0]                              req_day = '0;
   logic signed [cdac_pkg::OFFSET_BITS-1:0] req_day_offset = '0;
   logic signed [cdac_pkg::YEAR_BITS-1:0]   req_other_year = '0;
   logic [3:0]                              req_other_month = '0;
   logic [4:0]                              req_other_day = '0;
   logic                                    rsp_valid;
   logic signed [cdac_pkg::YEAR_BITS-1:0]   rsp_result_year;
   logic [3:0]                              rsp_result_month;
   logic [4:0]                              rsp_result_day;
   logic signed [1:0]                       rsp_order;
   logic                                    rsp_date_valid;
   logic                                    rsp_out_of_range;

   date_request_type pending_requests[$];
   date_result_type  expected_dates[$];
   int               mismatch_count = 0;
   int               idle_percent = 0;

   civil_date_add_and_compare dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Floor division for a positive divisor
   function automatic longint floor_div(longint a, longint b);
      return (a >= 0) ? a / b : -((-a + b - 1) / b);
   endfunction

   // Day number counted from 1970-01-01; raw month/day values go straight in
   function automatic longint days_since_epoch(longint y, longint m, longint d);
      longint era, yoe, doy;
      if (m <= 2) y = y - 1;
      era = floor_div(y, 400);
      yoe = y - era * 400;
      doy = (153 * (m + ((m > 2) ? -3 : 9)) + 2) / 5 + d - 1;
      return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
   endfunction

   function automatic bit is_leap(longint y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic bit is_real_date(longint y, longint m, longint d);
      longint lim;
      if (m < 1 || m > 12 || d < 1) return 1'b0;
      case (m)
         2:          lim = is_leap(y) ? 29 : 28;
         4, 6, 9, 11: lim = 30;
         default:    lim = 31;
      endcase
      return d <= lim;
   endfunction

   function automatic date_result_type predict_date(date_request_type r);
      date_result_type res;
      longint n, era, doe, yoe, doy, mp, ny, nm, nd, a, b;
      res = '{year: '0, month: '0, day: '0, order: cdac_pkg::ORD_EQUAL,
              date_valid: is_real_date(r.year, r.month, r.day), out_of_range: 1'b0};
      if (r.op == cdac_pkg::OP_ADD) begin
         n = days_since_epoch(r.year, r.month, r.day) + longint'(r.day_offset) + 719468;
         era = floor_div(n, 146097);
         doe = n - era * 146097;
         yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
         doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
         mp = (5 * doy + 2) / 153;
         nd = doy - (153 * mp + 2) / 5 + 1;
         nm = mp + ((mp < 10) ? 3 : -9);
         ny = yoe + era * 400 + ((nm <= 2) ? 1 : 0);
         if (ny < cdac_pkg::YEAR_MIN || ny > cdac_pkg::YEAR_MAX) begin
            res.out_of_range = 1'b1;
         end else begin
            res.year = ny[cdac_pkg::YEAR_BITS-1:0];
            res.month = nm[3:0];
            res.day = nd[4:0];
         end
      end else begin
         a = days_since_epoch(r.year, r.month, r.day);
         b = days_since_epoch(r.other_year, r.other_month, r.other_day);
         res.order = (a < b) ? cdac_pkg::ORD_LESS
                   : ((a > b) ? cdac_pkg::ORD_GREATER : cdac_pkg::ORD_EQUAL);
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch at %0t: %s got %0d want %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   function automatic date_request_type random_request();
      date_request_type r;
      r.op = 1'($urandom_range(0, 1));
      // Mostly near-present years and real dates, sometimes the full field
      r.year = ($urandom_range(0, 3) == 0) ? $signed(16'($urandom))
                                           : $signed(16'($urandom_range(1500, 2500)));
      r.month = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 12));
      r.day = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(1, 28));
      case ($urandom_range(0, 3))
         0:       r.day_offset = $signed(25'($urandom));
         1:       r.day_offset = $signed(11'($urandom));
         default: r.day_offset = $signed(20'($urandom));
      endcase
      r.other_year = ($urandom_range(0, 2) == 0) ? r.year : $signed(16'($urandom));
      r.other_month = ($urandom_range(0, 2) == 0) ? r.month : 4'($urandom);
      r.other_day = ($urandom_range(0, 2) == 0) ? r.day : 5'($urandom);
      return r;
   endfunction

   // Driver: present the next request at the falling edge, or idle
   always @(negedge clock) begin
      if (!reset && pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_percent) begin
         date_request_type r;
         r = pending_requests.pop_front();
         start <= 1'b1;
         req_op <= r.op;
         req_year <= r.year;
         req_month <= r.month;
         req_day <= r.day;
         req_day_offset <= r.day_offset;
         req_other_year <= r.other_year;
         req_other_month <= r.other_month;
         req_other_day <= r.other_day;
         expected_dates = {expected_dates, predict_date(r)};
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: check every strobed result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_dates.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            date_result_type e;
            e = expected_dates.pop_front();
            if (rsp_result_year !== e.year) report_mismatch("year", rsp_result_year, e.year);
            if (rsp_result_month !== e.month)
               report_mismatch("month", rsp_result_month, e.month);
            if (rsp_result_day !== e.day) report_mismatch("day", rsp_result_day, e.day);
            if (rsp_order !== e.order) report_mismatch("order", rsp_order, e.order);
            if (rsp_date_valid !== e.date_valid)
               report_mismatch("date_valid", rsp_date_valid, e.date_valid);
            if (rsp_out_of_range !== e.out_of_range)
               report_mismatch("out_of_range", rsp_out_of_range, e.out_of_range);
         end
      end
   end

   task automatic queue_request(logic op, int y, int m, int d, int off, int oy, int om, int od);
      date_request_type r;
      r.op = op;
      r.year = y[cdac_pkg::YEAR_BITS-1:0];
      r.month = m[3:0];
      r.day = d[4:0];
      r.day_offset = off[cdac_pkg::OFFSET_BITS-1:0];
      r.other_year = oy[cdac_pkg::YEAR_BITS-1:0];
      r.other_month = om[3:0];
      r.other_day = od[4:0];
      pending_requests = {pending_requests, r};
   endtask

   initial begin
      int phase_percent[4] = '{0, 48, 0, 25};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // Directed: epoch, leap days, century rules, invalid dates, field extremes
      queue_request(cdac_pkg::OP_ADD, 1970, 1, 1, 0, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, 2000, 2, 29, 1, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, 1900, 2, 29, 0, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, 2024, 12, 31, 1, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, 2024, 3, 1, -1, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, 2023, 0, 0, 0, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, 2023, 15, 31, 0, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, 2023, 4, 31, 0, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, 32767, 12, 31, 1, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, -32768, 1, 1, -1, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, 32767, 12, 31, 16777215, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, -32768, 1, 1, -16777216, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, 0, 2, 29, -16777216, 0, 0, 0);
      queue_request(cdac_pkg::OP_ADD, -1, 3, 1, 16777215, 0, 0, 0);
      queue_request(cdac_pkg::OP_CMP, 2024, 5, 5, 0, 2024, 5, 5);
      queue_request(cdac_pkg::OP_CMP, 2024, 5, 5, 0, 2024, 5, 6);
      queue_request(cdac_pkg::OP_CMP, 2024, 5, 6, 0, 2024, 5, 5);
      queue_request(cdac_pkg::OP_CMP, -32768, 0, 0, 0, 32767, 15, 31);
      queue_request(cdac_pkg::OP_CMP, 32767, 15, 31, 0, -32768, 0, 0);
      queue_request(cdac_pkg::OP_CMP, 2023, 13, 1, 0, 2024, 1, 1);
      queue_request(cdac_pkg::OP_CMP, 2024, 2, 0, 0, 2024, 1, 31);
      wait (pending_requests.size() == 0);
      // Random phases with different idle rates, two of them no-idle stretches
      foreach (phase_percent[p]) begin
         idle_percent = phase_percent[p];
         repeat (385) pending_requests = {pending_requests, random_request()};
         wait (pending_requests.size() == 0);
      end
      // Drain, then run on past the pipeline latency
      wait (expected_dates.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
design/cdac_pkg.sv
design/cdac_to_days.sv
design/cdac_from_days.sv
design/civil_date_add_and_compare.sv
tb/sv/civil_date_add_and_compare_test.sv
